/* rtl/stt_pkg.sv */
// Shared constants, types and helpers of the sorted time table.
`default_nettype none

package stt_pkg;

    localparam int DEPTH         = 64;
    localparam int IDX_W         = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int HOUR_W        = 10;
    localparam int MIN_W         = 6;
    localparam int IN_W          = 10;
    localparam int KEY_W         = 15;
    localparam int MINS_PER_HOUR = 60;

    typedef enum logic [2:0] {
        ACT_INSERT   = 3'd0,
        ACT_POP      = 3'd1,
        ACT_LIST_GT  = 3'd2,
        ACT_LIST_ALL = 3'd3,
        ACT_CLEAR    = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_LISTED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_KEY,
        S_INS,
        S_PUT,
        S_LIST,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
    } t_entry;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    // Sort key of a normalized time: hour * 60 + minute.
    function automatic logic [KEY_W-1:0] key_of(input logic [HOUR_W-1:0] h,
                                                input logic [MIN_W-1:0] m);
        return KEY_W'(h) * KEY_W'(MINS_PER_HOUR) + KEY_W'(m);
    endfunction

endpackage

`default_nettype wire

/* rtl/stt_norm.sv */
// Time normalizer: carry minutes into the hour, clamp negatives to zero.
`default_nettype none

module stt_norm
    import stt_pkg::*;
(
    input  wire logic signed [IN_W-1:0] i_hour,
    input  wire logic signed [IN_W-1:0] i_minute,
    output logic [HOUR_W-1:0]           o_hour,
    output logic [MIN_W-1:0]            o_minute
);

    logic [8:0]         m_pos;
    logic [13:0]        prod17;
    logic [3:0]         q_est;
    logic [9:0]         q60;
    logic [9:0]         r_est;
    logic [3:0]         quot;
    logic [9:0]         rem;
    logic signed [10:0] hour_sum;

    // Quotient by 60 as m*17/1024, which undershoots by at most one; fix once.
    assign m_pos  = i_minute[8:0];
    assign prod17 = 14'(m_pos) * 14'd17;
    assign q_est  = prod17[13:10];
    assign q60    = 10'(q_est) * 10'(MINS_PER_HOUR);
    assign r_est  = {1'b0, m_pos} - q60;

    always_comb begin
        if (r_est >= 10'(MINS_PER_HOUR)) begin
            quot = q_est + 4'd1;
            rem  = r_est - 10'(MINS_PER_HOUR);
        end else begin
            quot = q_est;
            rem  = r_est;
        end
    end

    always_comb begin
        if (i_minute >= 10'sd60) begin
            hour_sum = {i_hour[IN_W-1], i_hour} + $signed({7'd0, quot});
            o_minute = rem[MIN_W-1:0];
        end else begin
            hour_sum = {i_hour[IN_W-1], i_hour};
            o_minute = i_minute[IN_W-1] ? '0 : i_minute[MIN_W-1:0];
        end
        o_hour = hour_sum[10] ? '0 : hour_sum[HOUR_W-1:0];
    end

endmodule

`default_nettype wire

/* rtl/sorted_time_table.sv */
// Top level of the sorted time table: sequencer around one entry memory.
//
//  channel   dir   handshake                    payload
//  s_axis    in    s_axis_tvalid/s_axis_tready  tdata: hour_in, minute_in; tuser: action
//  m_axis    out   m_axis_tvalid/m_axis_tready  tdata: hour_out, minute_out; tuser: status;
//                                               tlast: last
//
//  Every transaction passes S_NORM and S_KEY. Pop, clear, unknown, dropped insert and insert
//  into an empty table then answer from S_RESP; other inserts scan S_INS back over each entry
//  later than the new time, via S_PUT if all are, to S_RESP; a list walks S_LIST over every
//  entry, via S_RESP if none qualifies. The single read port makes scans go one entry at a
//  time. Reset clears the control registers only; the memory needs no clearing pass. A stalled
//  output holds the sequencer where it pushes; the next input waits only for the final push.
`default_nettype none

module sorted_time_table
    import stt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // [9:0] hour_in, [19:10] minute_in, [23:20] zero
    input  wire logic [23:0] s_axis_tdata,
    // [2:0] action
    input  wire logic [2:0]  s_axis_tuser,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [9:0] hour_out, [15:10] minute_out
    output logic [15:0]      m_axis_tdata,
    // [1:0] status
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready
);

    // Entry memory, kept as a ring: logical index 0 sits at r_head.
    t_entry mem [DEPTH];
    t_entry rd_entry;

    t_state  r_state, n_state;
    t_idx    r_idx, n_idx;
    t_idx    r_head, n_head;
    t_cnt    r_count, n_count;
    t_status r_status, n_status;

    t_action                  r_action;
    logic signed [IN_W-1:0]   r_hour_raw;
    logic signed [IN_W-1:0]   r_min_raw;
    logic [HOUR_W-1:0]        r_hour;
    logic [MIN_W-1:0]         r_minute;
    logic [KEY_W-1:0]         r_key;

    logic [HOUR_W-1:0] norm_hour;
    logic [MIN_W-1:0]  norm_minute;

    logic              r_out_valid;
    logic [HOUR_W-1:0] r_out_hour;
    logic [MIN_W-1:0]  r_out_minute;
    t_status           r_out_status;
    logic              r_out_last;

    logic              out_free;
    logic              push;
    logic [HOUR_W-1:0] push_hour;
    logic [MIN_W-1:0]  push_minute;
    t_status           push_status;
    logic              push_last;

    logic   wr_en;
    t_idx   wr_addr;
    t_entry wr_data;
    t_idx   rd_addr;

    logic [KEY_W-1:0] rd_key;
    t_cnt             cnt_m1;
    logic             at_last;
    logic             in_accept;

    // Map a logical index onto the ring.
    function automatic t_idx phys(input t_idx head, input t_idx idx);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (IDX_W+1)'(DEPTH)) begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    stt_norm u_norm (
        .i_hour   (r_hour_raw),
        .i_minute (r_min_raw),
        .o_hour   (norm_hour),
        .o_minute (norm_minute)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign rd_key  = key_of(rd_entry.hour, rd_entry.minute);
    assign cnt_m1  = r_count - t_cnt'(1);
    assign at_last = (r_idx == cnt_m1[IDX_W-1:0]);

    // Memory: one write and one registered read per cycle. The read follows the
    // next index, so rd_entry always holds the entry at r_idx.
    assign rd_addr = phys(r_head, n_idx);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_entry <= mem[rd_addr];
    end

    // Sequencer: next state, memory writes and result pushes.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_head      = r_head;
        n_count     = r_count;
        n_status    = r_status;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '{hour: r_hour, minute: r_minute};
        push        = 1'b0;
        push_hour   = '0;
        push_minute = '0;
        push_status = r_status;
        push_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                n_state = S_KEY;
            end
            S_KEY: begin
                n_status = ST_DONE;
                n_state  = S_RESP;
                unique case (r_action)
                    ACT_INSERT: begin
                        if (r_count == t_cnt'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else if (r_count == '0) begin
                            wr_en   = 1'b1;
                            wr_addr = r_head;
                            n_count = t_cnt'(1);
                        end else begin
                            // start the backward scan at the last (latest) entry
                            n_idx   = cnt_m1[IDX_W-1:0];
                            n_state = S_INS;
                        end
                    end
                    ACT_POP: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_head  = phys(r_head, t_idx'(1));
                            n_count = cnt_m1;
                        end
                    end
                    ACT_LIST_GT, ACT_LIST_ALL: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_idx   = '0;
                            n_state = S_LIST;
                        end
                    end
                    ACT_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_INS: begin
                wr_en   = 1'b1;
                wr_addr = phys(r_head, r_idx + t_idx'(1));
                if (rd_key > r_key) begin
                    // shift this entry up by one and keep scanning
                    wr_data = rd_entry;
                    if (r_idx == '0) begin
                        n_state = S_PUT;
                    end else begin
                        n_idx = r_idx - t_idx'(1);
                    end
                end else begin
                    n_count = r_count + t_cnt'(1);
                    n_state = S_RESP;
                end
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_head;
                n_count = r_count + t_cnt'(1);
                n_state = S_RESP;
            end
            S_LIST: begin
                // the store is sorted: once one entry qualifies, all later ones do
                if (r_action == ACT_LIST_ALL || rd_key > r_key) begin
                    if (out_free) begin
                        push        = 1'b1;
                        push_hour   = rd_entry.hour;
                        push_minute = rd_entry.minute;
                        push_status = ST_LISTED;
                        push_last   = at_last;
                        if (at_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx = r_idx + t_idx'(1);
                        end
                    end
                end else if (at_last) begin
                    n_status = ST_EMPTY;
                    n_state  = S_RESP;
                end else begin
                    n_idx = r_idx + t_idx'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    push        = 1'b1;
                    push_status = r_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_status    <= ST_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_head   <= n_head;
            r_count  <= n_count;
            r_status <= n_status;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: capture the request, its normalized time and key, and each pushed result.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action   <= t_action'(s_axis_tuser);
            r_hour_raw <= $signed(s_axis_tdata[IN_W-1:0]);
            r_min_raw  <= $signed(s_axis_tdata[2*IN_W-1:IN_W]);
        end
        if (r_state == S_NORM) begin
            r_hour   <= norm_hour;
            r_minute <= norm_minute;
        end
        if (r_state == S_KEY) begin
            r_key <= key_of(r_hour, r_minute);
        end
        if (push) begin
            r_out_hour   <= push_hour;
            r_out_minute <= push_minute;
            r_out_status <= push_status;
            r_out_last   <= push_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_minute, r_out_hour};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

/* tb/sorted_time_table_checker.sv */
// Checker for the sorted time table: predicts every result and compares it on the output channel.
module sorted_time_table_checker
    import stt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [23:0] s_axis_tdata,     // [9:0] hour_in, [19:10] minute_in, [23:20] zero
    input  wire logic [2:0]  s_axis_tuser,     // [2:0] action
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [15:0] m_axis_tdata,     // [9:0] hour_out, [15:10] minute_out
    input  wire logic [1:0]  m_axis_tuser,     // [1:0] status
    input  wire logic        m_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        t_status           status;
        logic              last;
    } t_reply;

    t_entry stored_times[$];
    t_reply reply_q[$];
    int     mismatches = 0;

    function automatic int sort_key(input t_entry e);
        return int'(e.hour) * MINS_PER_HOUR + int'(e.minute);
    endfunction

    // Carry minutes past the hour first, then clamp negative minute and hour to zero.
    function automatic t_entry normalize_time(input logic signed [IN_W-1:0] hour_raw,
                                              input logic signed [IN_W-1:0] minute_raw);
        int     hour_v;
        int     minute_v;
        t_entry e;
        hour_v   = hour_raw;
        minute_v = minute_raw;
        if (minute_v >= MINS_PER_HOUR) begin
            hour_v   += minute_v / MINS_PER_HOUR;
            minute_v  = minute_v % MINS_PER_HOUR;
        end
        if (minute_v < 0) minute_v = 0;
        if (hour_v < 0) hour_v = 0;
        e.hour   = hour_v[HOUR_W-1:0];
        e.minute = minute_v[MIN_W-1:0];
        return e;
    endfunction

    task automatic push_reply(input logic [HOUR_W-1:0] hour, input logic [MIN_W-1:0] minute,
                              input t_status status, input logic last);
        t_reply r;
        r.hour   = hour;
        r.minute = minute;
        r.status = status;
        r.last   = last;
        reply_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTED)
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Apply one command to the shadow table and queue the results it causes.
    task automatic predict_command(input logic [2:0] act, input logic [23:0] data);
        t_entry when;
        t_entry hits[$];
        int     pos;
        when = normalize_time(data[IN_W-1:0], data[2*IN_W-1:IN_W]);
        case (act)
            ACT_INSERT: begin
                if (stored_times.size() >= DEPTH) begin
                    push_reply('0, '0, ST_FULL, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < stored_times.size() &&
                           sort_key(stored_times[pos]) <= sort_key(when))
                        pos++;
                    stored_times.insert(pos, when);
                    push_reply('0, '0, ST_DONE, 1'b1);
                end
            end
            ACT_POP: begin
                if (stored_times.size() == 0) begin
                    push_reply('0, '0, ST_EMPTY, 1'b1);
                end else begin
                    void'(stored_times.pop_front());
                    push_reply('0, '0, ST_DONE, 1'b1);
                end
            end
            ACT_LIST_GT, ACT_LIST_ALL: begin
                foreach (stored_times[i])
                    if (act == ACT_LIST_ALL || sort_key(stored_times[i]) > sort_key(when))
                        hits.push_back(stored_times[i]);
                if (hits.size() == 0)
                    push_reply('0, '0, ST_EMPTY, 1'b1);
                foreach (hits[i])
                    push_reply(hits[i].hour, hits[i].minute, ST_LISTED, i == hits.size() - 1);
            end
            ACT_CLEAR: begin
                stored_times.delete();
                push_reply('0, '0, ST_DONE, 1'b1);
            end
            default: push_reply('0, '0, ST_DONE, 1'b1);
        endcase
    endtask

    task automatic check_reply();
        t_reply want;
        if (reply_q.size() == 0) begin
            report_mismatch("result with nothing outstanding", m_axis_tdata, 0);
            return;
        end
        want = reply_q.pop_front();
        if (m_axis_tdata[HOUR_W-1:0] !== want.hour)
            report_mismatch("hour_out", m_axis_tdata[HOUR_W-1:0], want.hour);
        if (m_axis_tdata[HOUR_W+MIN_W-1:HOUR_W] !== want.minute)
            report_mismatch("minute_out", m_axis_tdata[HOUR_W+MIN_W-1:HOUR_W], want.minute);
        if (m_axis_tuser !== want.status)
            report_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tlast !== want.last)
            report_mismatch("last", m_axis_tlast, want.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_times.delete();
            reply_q.delete();
        end else begin
            // A result can never stem from a command taken on the same edge.
            if (m_axis_tvalid && m_axis_tready) check_reply();
            if (s_axis_tvalid && s_axis_tready) predict_command(s_axis_tuser, s_axis_tdata);
        end
        o_pending    <= reply_q.size();
        o_fail_count <= mismatches;
    end

endmodule

/* tb/sorted_time_table_test.sv */
// Top of the sorted time table testbench: clock, reset, stimulus, output pacing and verdict.
module sorted_time_table_test
    import stt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Action codes the block has no name for; it must answer them with a plain done.
    localparam logic [2:0] ACT_UNUSED_MIN = 3'd5;
    localparam logic [2:0] ACT_UNUSED_MID = 3'd6;
    localparam logic [2:0] ACT_UNUSED_MAX = 3'd7;

    localparam int RESET_CYCLES    = 6;
    localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall that fills the block
    localparam int SETTLE_CYCLES   = 100;   // longest list plus margin
    localparam int STALL_LIMIT     = 3000;  // cycles with no transaction on either side

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic [23:0] s_axis_tdata  = '0;    // [9:0] hour_in, [19:10] minute_in, [23:20] zero
    logic [2:0]  s_axis_tuser  = '0;    // [2:0] action
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] m_axis_tdata;          // [9:0] hour_out, [15:10] minute_out
    logic [1:0]  m_axis_tuser;          // [1:0] status
    logic        m_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;

    int          fail_count;
    int          pending;

    // Phase hints shared between the sender and the receiver.
    logic        quiet = 1'b0;          // no idling on either side
    logic        flood = 1'b0;          // sender back to back, receiver holds off once

    sorted_time_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    sorted_time_table_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one command and hold it until the block takes it; then maybe idle a burst.
    // The edge that ends the wait is the accepting edge, so tvalid is never left high
    // across a further edge with stale data.
    task automatic send_item(input logic [2:0] act,
                             input logic signed [IN_W-1:0] hour,
                             input logic signed [IN_W-1:0] minute);
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'b0000, minute, hour};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!quiet && !flood && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Draw a time: raw 10-bit values reach negatives and large carries, the narrow
    // pools make equal keys frequent so insert ordering after equals gets exercised.
    function automatic void pick_time(output logic [IN_W-1:0] hour,
                                      output logic [IN_W-1:0] minute);
        case ($urandom_range(0, 3))
            0: begin
                hour   = IN_W'($urandom);
                minute = IN_W'($urandom);
            end
            1: begin
                hour   = IN_W'($urandom_range(0, 23));
                minute = IN_W'($urandom_range(0, 59));
            end
            2: begin
                hour   = IN_W'($urandom_range(0, 3));
                minute = IN_W'($urandom_range(0, 3) * 30);
            end
            default: begin
                hour   = IN_W'($urandom_range(0, 30));
                minute = IN_W'($urandom_range(0, 200));
            end
        endcase
    endfunction

    // Random command; insert_pct sets how hard the table is pushed toward full.
    task automatic send_random(input int insert_pct);
        logic [2:0]      act;
        logic [IN_W-1:0] hour;
        logic [IN_W-1:0] minute;
        int              pick;
        pick_time(hour, minute);
        if ($urandom_range(0, 99) < insert_pct) begin
            act = ACT_INSERT;
        end else begin
            pick = $urandom_range(0, 19);
            if (pick < 6)       act = ACT_POP;
            else if (pick < 12) act = ACT_LIST_GT;
            else if (pick < 16) act = ACT_LIST_ALL;
            else if (pick < 17) act = ACT_CLEAR;
            else                act = 3'($urandom_range(ACT_UNUSED_MIN, ACT_UNUSED_MAX));
        end
        send_item(act, hour, minute);
    endtask

    task automatic send_random_insert();
        logic [IN_W-1:0] hour;
        logic [IN_W-1:0] minute;
        pick_time(hour, minute);
        send_item(ACT_INSERT, hour, minute);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Receiver: random stall bursts, calm stretches, and one long hold-off in the flood
    // phase so the output register and the sequencer back up into the input.
    initial begin : receiver
        int   pick;
        logic hold_done;
        hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (flood && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                m_axis_tready <= 1'b1;
                hold_done = 1'b1;
            end else if (!quiet) begin
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(posedge i_clk);
                    m_axis_tready <= 1'b1;
                end else if (pick == 2) begin
                    m_axis_tready <= 1'b1;
                    repeat ($urandom_range(20, 60)) @(posedge i_clk);
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("sorted_time_table_test: FAIL");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: pop and both lists report nothing found.
        send_item(ACT_POP, 0, 0);
        send_item(ACT_LIST_ALL, 0, 0);
        send_item(ACT_LIST_GT, -512, -512);

        // Field extremes and normalization corners.
        send_item(ACT_INSERT, 0, 0);
        send_item(ACT_INSERT, -512, -512);   // clamps to 0:00, lands after the equal key
        send_item(ACT_INSERT, 511, 511);     // carries to 519:31, the largest time
        send_item(ACT_INSERT, 5, 60);        // minute of exactly 60 carries to 6:00
        send_item(ACT_INSERT, -3, 75);       // carry leaves the hour negative, clamp to 0:15
        send_item(ACT_INSERT, 7, -1);        // negative minute clamps to 7:00
        send_item(ACT_INSERT, 2, 59);
        send_item(ACT_INSERT, 6, 0);         // equal key to 6:00, goes after it
        send_item(ACT_INSERT, -1, 511);      // carry onto a negative hour: 7:31
        send_item(ACT_LIST_ALL, 0, 0);
        send_item(ACT_LIST_GT, 6, 0);        // strictly later than 6:00 only
        send_item(ACT_LIST_GT, 511, 511);    // nothing beyond the largest time
        send_item(ACT_LIST_GT, -512, 0);     // threshold clamps to 0:00
        send_item(ACT_POP, 0, 0);
        send_item(ACT_UNUSED_MIN, 0, 0);
        send_item(ACT_UNUSED_MID, 100, 100);
        send_item(ACT_UNUSED_MAX, -1, -1);
        send_item(ACT_LIST_ALL, 0, 0);
        send_item(ACT_CLEAR, 0, 0);
        send_item(ACT_LIST_ALL, 0, 0);
        send_item(ACT_POP, 0, 0);
        wait_for_results();

        // Mixed random traffic with idling on both sides.
        repeat (10) send_random(55);
        wait_for_results();

        // Flood: offer back to back while the receiver holds off; lists dominate so
        // each command stacks up many results behind the stall.
        flood <= 1'b1;
        @(posedge i_clk);
        repeat (10) send_random(30);
        wait_for_results();
        flood <= 1'b0;

        // Fill the table past its depth, then work on the full table: dropped inserts,
        // full-length lists, pops that reopen a slot.
        repeat (68) send_random_insert();
        send_item(ACT_LIST_ALL, 0, 0);
        repeat (6) send_random(50);
        wait_for_results();

        // Closing stretch without idling on either side.
        quiet <= 1'b1;
        @(posedge i_clk);
        repeat (8) send_random(40);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("sorted_time_table_test: PASS");
        else
            $display("sorted_time_table_test: FAIL");
        $finish;
    end

endmodule
